// ===== src/prs_pkg.sv =====
// prs_pkg: shared types and constants of the poi record stream parser
// used by prs_front, prs_queue, prs_back and poi_record_stream_parser
// no dependencies

package prs_pkg;

	// record type codes
	localparam logic [7:0] TypeSkipLenA = 8'd0;
	localparam logic [7:0] TypeHeader   = 8'd1;
	localparam logic [7:0] TypeWptA     = 8'd2;
	localparam logic [7:0] TypeWptB     = 8'd3;
	localparam logic [7:0] TypeShortA   = 8'd8;
	localparam logic [7:0] TypeShortB   = 8'd9;
	localparam logic [7:0] TypeShortC   = 8'd24;
	localparam logic [7:0] TypeShortD   = 8'd25;
	localparam logic [7:0] TypeSkipLenB = 8'd100;

	// size constants
	localparam logic [30:0] MaxSizeReset = 31'd100000;
	localparam logic [30:0] WptHdrLen    = 31'd13;
	localparam logic [30:0] SkipHdrLen   = 31'd5;
	localparam logic [30:0] ShortExtra   = 31'd6;
	localparam logic [30:0] HeaderSkip   = 31'd20;

	// result kinds
	typedef enum logic [1:0] {
		KIND_COORD  = 2'd0,
		KIND_TEXT   = 2'd1,
		KIND_NOTICE = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	// error codes
	localparam logic ErrBadSize = 1'b0;
	localparam logic ErrEndInRec = 1'b1;

	// queue between front and back
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  longitude;
		logic [31:0]  latitude;
		logic [7:0]   text_byte;
		logic         last_of_record;
		logic         carries_unique_id;
		logic [7:0]   record_type;
		logic         error_code;
	} result_t;

endpackage

// ===== src/prs_front.sv =====
// prs_front: byte-level record parser, one input beat per cycle while in_fire is high
// pushes at most one result per beat into the queue; depends on prs_pkg

module prs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_fire,
	input  logic [7:0]              in_byte,
	input  logic                    in_eos,
	input  logic                    cfg_we,
	input  logic [30:0]             cfg_wdata,
	output logic                    push,
	output prs_pkg::result_t        push_data
);

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_SKIP,
		PH_LON,
		PH_LAT,
		PH_DESC,
		PH_SHORT
	} phase_t;

	phase_t       phase_q, phase_d;
	logic [7:0]   type_q, type_d;
	logic [1:0]   idx_q, idx_d;
	logic [31:0]  word_q, word_d;
	logic [31:0]  lon_q, lon_d;
	logic [30:0]  rem_q, rem_d;
	logic         halted_q, halted_d;
	logic [30:0]  max_q;

	logic [31:0]  word_in;
	logic         word_done;
	logic [30:0]  skip_sz;
	logic [30:0]  short_sz;
	logic [30:0]  rem_dec;
	logic         wpt_bad;
	logic         skip_bad;
	logic         uid;

	// merge incoming byte into its lane
	always_comb begin
		word_in = word_q;
		case (idx_q)
			2'd0: word_in[7:0]   = in_byte;
			2'd1: word_in[15:8]  = in_byte;
			2'd2: word_in[23:16] = in_byte;
			default: word_in[31:24] = in_byte;
		endcase
	end

	assign word_done = (idx_q == 2'd3);
	assign skip_sz   = word_in[30:0] - prs_pkg::SkipHdrLen;
	assign short_sz  = {23'd0, in_byte} + prs_pkg::ShortExtra;
	assign rem_dec   = (rem_q != 31'd0) ? rem_q - 31'd1 : rem_q;
	assign uid       = (type_q == prs_pkg::TypeWptB);
	assign wpt_bad   = word_in[31] || (word_in[30:0] < prs_pkg::WptHdrLen) ||
	                   (word_in[30:0] > max_q);
	assign skip_bad  = word_in[31] || (word_in[30:0] < prs_pkg::SkipHdrLen) ||
	                   (skip_sz > max_q);

	always_comb begin
		phase_d   = phase_q;
		type_d    = type_q;
		idx_d     = idx_q;
		word_d    = word_q;
		lon_d     = lon_q;
		rem_d     = rem_q;
		halted_d  = halted_q;
		push      = 1'b0;
		push_data = '0;
		if (in_fire && !halted_q) begin
			if (in_eos) begin
				if (phase_q != PH_TYPE) begin
					push                 = 1'b1;
					push_data.kind       = prs_pkg::KIND_ERROR;
					push_data.error_code = prs_pkg::ErrEndInRec;
					halted_d             = 1'b1;
				end
			end else begin
				unique case (phase_q)
					PH_TYPE: begin
						type_d = in_byte;
						idx_d  = 2'd0;
						word_d = '0;
						unique case (in_byte) inside
							prs_pkg::TypeSkipLenA, prs_pkg::TypeSkipLenB,
							prs_pkg::TypeWptA, prs_pkg::TypeWptB: begin
								phase_d = PH_LEN;
							end
							prs_pkg::TypeHeader: begin
								rem_d   = prs_pkg::HeaderSkip;
								phase_d = PH_SKIP;
							end
							prs_pkg::TypeShortA, prs_pkg::TypeShortB,
							prs_pkg::TypeShortC, prs_pkg::TypeShortD: begin
								phase_d = PH_SHORT;
							end
							default: begin
								push                  = 1'b1;
								push_data.kind        = prs_pkg::KIND_NOTICE;
								push_data.record_type = in_byte;
							end
						endcase
					end
					PH_LEN: begin
						idx_d  = idx_q + 2'd1;
						word_d = word_in;
						if (word_done) begin
							word_d = '0;
							if (type_q == prs_pkg::TypeWptA || uid) begin
								if (wpt_bad) begin
									push                 = 1'b1;
									push_data.kind       = prs_pkg::KIND_ERROR;
									push_data.error_code = prs_pkg::ErrBadSize;
									halted_d             = 1'b1;
								end else begin
									rem_d   = word_in[30:0] - prs_pkg::WptHdrLen;
									phase_d = PH_LON;
								end
							end else if (skip_bad) begin
								push                 = 1'b1;
								push_data.kind       = prs_pkg::KIND_ERROR;
								push_data.error_code = prs_pkg::ErrBadSize;
								halted_d             = 1'b1;
							end else begin
								rem_d   = skip_sz;
								phase_d = (skip_sz != 31'd0) ? PH_SKIP : PH_TYPE;
							end
						end
					end
					PH_SKIP: begin
						rem_d = rem_dec;
						if (rem_dec == 31'd0) begin
							phase_d = PH_TYPE;
						end
					end
					PH_LON: begin
						idx_d  = idx_q + 2'd1;
						word_d = word_in;
						if (word_done) begin
							lon_d   = word_in;
							word_d  = '0;
							phase_d = PH_LAT;
						end
					end
					PH_LAT: begin
						idx_d  = idx_q + 2'd1;
						word_d = word_in;
						if (word_done) begin
							push                        = 1'b1;
							push_data.kind              = prs_pkg::KIND_COORD;
							push_data.longitude         = lon_q;
							push_data.latitude          = word_in;
							push_data.last_of_record    = (rem_q == 31'd0);
							push_data.carries_unique_id = uid;
							word_d  = '0;
							phase_d = (rem_q != 31'd0) ? PH_DESC : PH_TYPE;
						end
					end
					PH_DESC: begin
						rem_d                       = rem_dec;
						push                        = 1'b1;
						push_data.kind              = prs_pkg::KIND_TEXT;
						push_data.text_byte         = in_byte;
						push_data.last_of_record    = (rem_dec == 31'd0);
						push_data.carries_unique_id = uid;
						if (rem_dec == 31'd0) begin
							phase_d = PH_TYPE;
						end
					end
					PH_SHORT: begin
						if (short_sz > max_q) begin
							push                 = 1'b1;
							push_data.kind       = prs_pkg::KIND_ERROR;
							push_data.error_code = prs_pkg::ErrBadSize;
							halted_d             = 1'b1;
						end else begin
							rem_d   = short_sz;
							phase_d = PH_SKIP;
						end
					end
					default: begin
						phase_d = PH_TYPE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			type_q   <= '0;
			idx_q    <= '0;
			word_q   <= '0;
			lon_q    <= '0;
			rem_q    <= '0;
			halted_q <= 1'b0;
			max_q    <= prs_pkg::MaxSizeReset;
		end else begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			idx_q    <= idx_d;
			word_q   <= word_d;
			lon_q    <= lon_d;
			rem_q    <= rem_d;
			halted_q <= halted_d;
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
		end
	end

	// halt is sticky until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag dropped without reset");

	// every error result halts the parser
	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		push && (push_data.kind == prs_pkg::KIND_ERROR) |=> halted_q)
		else $error("error emitted without halting");

	// nothing is emitted once halted
	a_quiet_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !push)
		else $error("result emitted while halted");

endmodule

// ===== src/prs_queue.sv =====
// prs_queue: short register queue between parser front and output back
// holds prs_pkg::result_t entries; depends on prs_pkg

module prs_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  prs_pkg::result_t    push_data,
	input  logic                pop,
	output logic                full,
	output logic                not_empty,
	output prs_pkg::result_t    head
);

	prs_pkg::result_t              mem_q [prs_pkg::QDepth];
	logic [prs_pkg::QAw-1:0]       wr_q;
	logic [prs_pkg::QAw-1:0]       rd_q;
	logic [prs_pkg::QCntW-1:0]     cnt_q;

	assign full      = (cnt_q == prs_pkg::QCntW'(prs_pkg::QDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= prs_pkg::QCntW'(prs_pkg::QDepth))
		else $error("queue count out of range");

endmodule

// ===== src/prs_back.sv =====
// prs_back: output register that drains the queue onto the result stream
// packs result_t into tdata/tuser/tlast; depends on prs_pkg

module prs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  prs_pkg::result_t    q_head,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [87:0]         m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);

	logic               valid_q;
	prs_pkg::result_t   res_q;

	// load when the register is empty or being taken this cycle
	assign q_pop = q_not_empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_head;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last_of_record;
	assign m_tdata  = {6'd0, res_q.error_code, res_q.record_type,
	                   res_q.carries_unique_id, res_q.text_byte,
	                   res_q.latitude, res_q.longitude};

endmodule

// ===== src/poi_record_stream_parser.sv =====
// poi_record_stream_parser: top level of the point-of-interest record parser
// instantiates prs_front, prs_queue and prs_back; depends on prs_pkg

// The parser takes one file byte per beat on the s_ group and can accept a
// new beat every cycle while the queue is not full: each byte is one state
// update in the front parser, which yields at most one result per byte.
// Results go into a four-entry queue and then an output register that
// drives the m_ group, so a stalled consumer only backs up input once the
// queue holds four results; s_tready drops only while the queue is full.
// Each result reaches m_tvalid through the queue and the output register.
// s_tlast marks end of file (the data byte is then ignored): at a record
// boundary it is silently absorbed, inside a record it yields an error
// result. Any error (bad size or end inside a record) halts the parser;
// further beats are accepted and dropped until arst_n. The size limit
// register resets to 100000 and may only be written while the block is
// idle.

module poi_record_stream_parser (
	input  logic          clk,
	input  logic          arst_n,
	// size limit register
	input  logic          cfg_we,
	input  logic [30:0]   cfg_wdata,       // max_record_size
	// byte input stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,         // [7:0] data_byte
	input  logic          s_tlast,         // end_of_stream
	// result stream
	output logic          m_tvalid,
	input  logic          m_tready,
	// [31:0] longitude, [63:32] latitude, [71:64] text_byte,
	// [72] carries_unique_id, [80:73] record_type, [81] error_code, rest zero
	output logic [87:0]   m_tdata,
	output logic [1:0]    m_tuser,         // [1:0] result_kind
	output logic          m_tlast          // last_of_record
);

	logic               in_fire;
	logic               push;
	prs_pkg::result_t   push_data;
	logic               q_full;
	logic               q_not_empty;
	logic               q_pop;
	prs_pkg::result_t   q_head;

	// input is taken whenever the queue has room for a possible result
	assign s_tready = !q_full;
	assign in_fire  = s_tvalid && s_tready;

	// front: classify each beat and update parse state
	prs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.in_byte   (s_tdata),
		.in_eos    (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_data (push_data)
	);

	// decoupling queue
	prs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: output register and packing
	prs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

endmodule

// ===== tb/poi_record_stream_parser_test.sv =====
`timescale 1ns / 1ps
// poi_record_stream_parser_test: self-checking bench for the poi record parser
// streams file bytes with random gaps and stalls, predicts every result beat;
// depends on prs_pkg and poi_record_stream_parser

module poi_record_stream_parser_test;
	import prs_pkg::*;

	// cycles to let no-result bytes clear the front parser before a register write
	localparam int DrainCycles = 12;

	typedef enum logic [2:0] {
		AWAIT_TYPE,
		READ_LEN,
		SKIPPING,
		READ_LON,
		READ_LAT,
		READ_DESC,
		READ_SHORT
	} parse_phase_t;

	// ways to end the run with the parser halted
	typedef enum logic [2:0] {
		END_IN_RECORD,
		WPT_SHORT_LEN,
		WPT_NEG_LEN,
		WPT_LONG_LEN,
		SKIP_NEG_LEN,
		SKIP_LONG_LEN,
		SHORT_TOO_BIG
	} halt_case_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} file_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	poi_record_stream_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// bytes waiting for the driver, and results the parser still owes us
	file_beat_t  file_bytes[$];
	file_beat_t  beat_now;
	result_t     due_results[$];
	int          fail_count = 0;
	int          counted = 0;
	int unsigned cyc = 0;
	logic [30:0] size_limit = MaxSizeReset;

	// a long window that recurs through the run where neither side idles
	logic calm;
	assign calm = (cyc % 2500) >= 2000;

	// parser state as we expect it to be
	parse_phase_t cur_phase = AWAIT_TYPE;
	logic [7:0]   cur_type = '0;
	logic [1:0]   byte_idx = '0;
	logic [31:0]  word_acc = '0;
	logic [31:0]  lon_hold = '0;
	logic [31:0]  bytes_left = '0;
	logic         halted = 1'b0;
	logic [30:0]  size_cap = MaxSizeReset;

	initial begin
		forever #2 clk = ~clk;
	end

	// timeout
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	function automatic void raise_error(input logic code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		due_results.push_back(r);
		halted = 1'b1;
	endfunction

	// little-endian word assembly, true once four bytes are in
	function automatic logic shift_in(input logic [7:0] b);
		word_acc = word_acc | (32'(b) << (8 * byte_idx));
		if (byte_idx != 2'd3) begin
			byte_idx = byte_idx + 2'd1;
			return 1'b0;
		end
		byte_idx = 2'd0;
		return 1'b1;
	endfunction

	function automatic void parse_file_byte(input file_beat_t beat);
		result_t r;
		longint  len;
		logic    uid;
		r = '0;
		uid = (cur_type == TypeWptB);
		if (halted)
			return;
		// end of file only hurts inside a record
		if (beat.eos) begin
			if (cur_phase != AWAIT_TYPE)
				raise_error(ErrEndInRec);
			return;
		end
		case (cur_phase)
			AWAIT_TYPE: begin
				cur_type = beat.data;
				byte_idx = '0;
				word_acc = '0;
				case (beat.data)
					TypeSkipLenA, TypeSkipLenB, TypeWptA, TypeWptB: cur_phase = READ_LEN;
					TypeHeader: begin
						bytes_left = 32'(HeaderSkip);
						cur_phase = SKIPPING;
					end
					TypeShortA, TypeShortB, TypeShortC, TypeShortD: cur_phase = READ_SHORT;
					default: begin
						r.kind = KIND_NOTICE;
						r.record_type = beat.data;
						due_results.push_back(r);
					end
				endcase
			end
			READ_LEN: begin
				if (shift_in(beat.data)) begin
					len = longint'($signed(word_acc));
					word_acc = '0;
					if (cur_type == TypeWptA || cur_type == TypeWptB) begin
						if (len < longint'(WptHdrLen) || len > longint'(size_cap)) begin
							raise_error(ErrBadSize);
						end else begin
							bytes_left = 32'(len - longint'(WptHdrLen));
							cur_phase = READ_LON;
						end
					end else begin
						len = len - longint'(SkipHdrLen);
						if (len < 0 || len > longint'(size_cap)) begin
							raise_error(ErrBadSize);
						end else begin
							bytes_left = 32'(len);
							cur_phase = (bytes_left != 0) ? SKIPPING : AWAIT_TYPE;
						end
					end
				end
			end
			SKIPPING: begin
				if (bytes_left != 0)
					bytes_left = bytes_left - 1;
				if (bytes_left == 0)
					cur_phase = AWAIT_TYPE;
			end
			READ_LON: begin
				if (shift_in(beat.data)) begin
					lon_hold = word_acc;
					word_acc = '0;
					cur_phase = READ_LAT;
				end
			end
			READ_LAT: begin
				if (shift_in(beat.data)) begin
					r.kind = KIND_COORD;
					r.longitude = lon_hold;
					r.latitude = word_acc;
					r.last_of_record = (bytes_left == 0);
					r.carries_unique_id = uid;
					due_results.push_back(r);
					word_acc = '0;
					cur_phase = (bytes_left != 0) ? READ_DESC : AWAIT_TYPE;
				end
			end
			READ_DESC: begin
				if (bytes_left != 0)
					bytes_left = bytes_left - 1;
				r.kind = KIND_TEXT;
				r.text_byte = beat.data;
				r.last_of_record = (bytes_left == 0);
				r.carries_unique_id = uid;
				due_results.push_back(r);
				if (bytes_left == 0)
					cur_phase = AWAIT_TYPE;
			end
			READ_SHORT: begin
				if (longint'(beat.data) + longint'(ShortExtra) > longint'(size_cap)) begin
					raise_error(ErrBadSize);
				end else begin
					bytes_left = 32'(beat.data) + 32'(ShortExtra);
					cur_phase = SKIPPING;
				end
			end
			default: cur_phase = AWAIT_TYPE;
		endcase
	endfunction

	// ---------------------------------------------------------------- driver

	// a beat moves at an edge with s_tvalid and s_tready both high
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_file_byte(beat_now);
			if (!s_tvalid || s_tready) begin
				if (file_bytes.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
					beat_now = file_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= beat_now.data;
					s_tlast <= beat_now.eos;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	function automatic string show(input result_t r);
		return $sformatf("kind=%0d lon=%h lat=%h text=%h last=%b uid=%b type=%h err=%b",
			r.kind, r.longitude, r.latitude, r.text_byte, r.last_of_record,
			r.carries_unique_id, r.record_type, r.error_code);
	endfunction

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		cyc <= cyc + 1;
		if (arst_n)
			m_tready <= calm || $urandom_range(99) >= 34;
		if (m_tvalid && m_tready) begin
			// unpack the result beat
			got.kind = kind_t'(m_tuser);
			got.longitude = m_tdata[31:0];
			got.latitude = m_tdata[63:32];
			got.text_byte = m_tdata[71:64];
			got.carries_unique_id = m_tdata[72];
			got.record_type = m_tdata[80:73];
			got.error_code = m_tdata[81];
			got.last_of_record = m_tlast;
			if (due_results.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result: %s", show(got));
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind || got.longitude !== want.longitude ||
						got.latitude !== want.latitude || got.text_byte !== want.text_byte ||
						got.last_of_record !== want.last_of_record ||
						got.carries_unique_id !== want.carries_unique_id ||
						got.record_type !== want.record_type ||
						got.error_code !== want.error_code) begin
					if (fail_count < 10) begin
						$display("mismatch: expected %s", show(want));
						$display("          actual   %s", show(got));
					end
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic void put_byte(input logic [7:0] b);
		file_bytes.push_back('{data: b, eos: 1'b0});
		counted++;
	endfunction

	// end of file, data byte is junk
	function automatic void put_eos();
		file_bytes.push_back('{data: 8'($urandom), eos: 1'b1});
	endfunction

	function automatic void put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			put_byte(w[8 * i +: 8]);
	endfunction

	function automatic void put_skip_rec(input logic [7:0] t, input logic [31:0] len,
			input int body);
		put_byte(t);
		put_word(len);
		repeat (body) put_byte(8'($urandom));
	endfunction

	function automatic void put_wpt_rec(input logic [7:0] t, input logic [31:0] len,
			input logic [31:0] lon, input logic [31:0] lat, input int ndesc);
		put_byte(t);
		put_word(len);
		put_word(lon);
		put_word(lat);
		repeat (ndesc) put_byte(8'($urandom));
	endfunction

	function automatic void put_short_rec(input logic [7:0] t, input logic [7:0] b,
			input int body);
		put_byte(t);
		put_byte(b);
		repeat (body) put_byte(8'($urandom));
	endfunction

	function automatic logic [7:0] pick_short_type();
		case ($urandom_range(3))
			0: return TypeShortA;
			1: return TypeShortB;
			2: return TypeShortC;
			default: return TypeShortD;
		endcase
	endfunction

	function automatic logic [7:0] pick_unknown_type();
		logic [7:0] t;
		do begin
			t = 8'($urandom);
		end while (t inside {TypeSkipLenA, TypeSkipLenB, TypeHeader, TypeWptA, TypeWptB,
			TypeShortA, TypeShortB, TypeShortC, TypeShortD});
		return t;
	endfunction

	// coordinates lean on the signed extremes now and then
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly short bodies, sometimes longer ones, never above cap
	function automatic int pick_size(input int cap);
		int hi;
		hi = ($urandom_range(9) == 0) ? 120 : 12;
		if (hi > cap)
			hi = cap;
		return $urandom_range(hi);
	endfunction

	// one well-formed record for the current size limit, or a bit of noise
	function automatic void random_record();
		int lim;
		int sel;
		int n;
		lim = int'(size_limit);
		sel = $urandom_range(99);
		if (sel < 40 && lim >= int'(WptHdrLen)) begin
			n = pick_size(lim - int'(WptHdrLen));
			put_wpt_rec($urandom_range(1) ? TypeWptA : TypeWptB, 32'(n) + 32'(WptHdrLen),
				pick_coord(), pick_coord(), n);
		end else if (sel < 55) begin
			n = pick_size(lim);
			put_skip_rec($urandom_range(1) ? TypeSkipLenA : TypeSkipLenB,
				32'(n) + 32'(SkipHdrLen), n);
		end else if (sel < 60) begin
			put_byte(TypeHeader);
			repeat (HeaderSkip) put_byte(8'($urandom));
		end else if (sel < 75 && lim >= int'(ShortExtra)) begin
			n = pick_size(lim - int'(ShortExtra));
			if (n > 255)
				n = 255;
			put_short_rec(pick_short_type(), 8'(n), n + int'(ShortExtra));
		end else if (sel < 90) begin
			put_byte(pick_unknown_type());
		end else begin
			put_eos();
		end
	endfunction

	function automatic void fill_random(input int nbytes);
		counted = 0;
		while (counted < nbytes)
			random_record();
	endfunction

	function automatic logic busy();
		return file_bytes.size() != 0 || s_tvalid || due_results.size() != 0;
	endfunction

	// re-checks after the drain in case a beat was launched just as we looked
	task automatic wait_drained();
		do begin
			while (busy())
				@(posedge clk);
			repeat (DrainCycles) @(posedge clk);
		end while (busy());
	endtask

	task automatic write_limit(input logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_limit = v;
		size_cap = v;
	endtask

	initial begin : stimulus
		int           lim;
		int           cut;
		logic [31:0]  len;
		halt_case_t   how;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed records at the reset size limit
		put_skip_rec(TypeSkipLenA, 32'(SkipHdrLen), 0);             // zero skip
		put_skip_rec(TypeSkipLenB, 32'(SkipHdrLen) + 32'd2, 2);
		put_byte(TypeHeader);
		repeat (HeaderSkip) put_byte(8'($urandom));
		put_wpt_rec(TypeWptA, 32'(WptHdrLen), 32'h8000_0000, 32'h7FFF_FFFF, 0);
		put_wpt_rec(TypeWptB, 32'(WptHdrLen) + 32'd2, 32'h7FFF_FFFF, 32'h8000_0000, 2);
		put_wpt_rec(TypeWptA, 32'(WptHdrLen) + 32'd1, '0, '1, 1);
		put_short_rec(TypeShortA, 8'd0, int'(ShortExtra));
		put_short_rec(TypeShortB, 8'd1, 1 + int'(ShortExtra));
		put_short_rec(TypeShortC, 8'hFF, 255 + int'(ShortExtra));
		put_short_rec(TypeShortD, 8'd3, 3 + int'(ShortExtra));
		put_byte(8'hFF);                                              // unknown type
		put_byte(pick_unknown_type());
		put_eos();                                                    // end between records
		wait_drained();

		// widest limit
		write_limit(31'h7FFF_FFFF);
		fill_random(420);
		wait_drained();

		// zero limit: only empty skips, headers and notices get through
		write_limit('0);
		fill_random(70);
		wait_drained();

		// tight limit with records sized exactly at it
		lim = $urandom_range(60, int'(WptHdrLen));
		write_limit(31'(lim));
		put_wpt_rec(TypeWptB, 32'(lim), pick_coord(), pick_coord(), lim - int'(WptHdrLen));
		put_skip_rec(TypeSkipLenA, 32'(lim) + 32'(SkipHdrLen), lim);
		put_short_rec(pick_short_type(), 8'(lim - int'(ShortExtra)), lim);
		fill_random(280);
		wait_drained();

		write_limit(31'($urandom_range(100000, 100)));
		fill_random(420);
		wait_drained();

		// finish with one fatal record, then bytes the halted parser must drop
		lim = $urandom_range(200, 20);
		write_limit(31'(lim));
		how = halt_case_t'($urandom_range(6));
		case (how)
			END_IN_RECORD: begin
				do begin
					file_bytes.delete();
					random_record();
				end while (file_bytes.size() < 2);
				cut = $urandom_range(file_bytes.size() - 1, 1);
				while (file_bytes.size() > cut)
					file_bytes.delete(file_bytes.size() - 1);
				put_eos();
			end
			WPT_SHORT_LEN: begin
				put_wpt_rec(TypeWptA, 32'($urandom_range(int'(WptHdrLen) - 1)),
					pick_coord(), pick_coord(), 0);
			end
			WPT_NEG_LEN: begin
				put_wpt_rec(TypeWptB, $urandom | 32'h8000_0000, pick_coord(), pick_coord(), 0);
			end
			WPT_LONG_LEN: begin
				put_wpt_rec(TypeWptA, 32'(lim + 1 + $urandom_range(1000)),
					pick_coord(), pick_coord(), 0);
			end
			SKIP_NEG_LEN: begin
				len = $urandom_range(1) ? 32'($urandom_range(int'(SkipHdrLen) - 1))
					: ($urandom | 32'h8000_0000);
				put_skip_rec(TypeSkipLenB, len, 0);
			end
			SKIP_LONG_LEN: begin
				put_skip_rec(TypeSkipLenA, 32'(lim + int'(SkipHdrLen) + 1 + $urandom_range(1000)),
					0);
			end
			default: begin
				put_short_rec(pick_short_type(),
					8'($urandom_range(255, lim - int'(ShortExtra) + 1)), 0);
			end
		endcase
		repeat (20) begin
			if ($urandom_range(3) == 0)
				put_eos();
			else
				put_byte(8'($urandom));
		end
		wait_drained();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== poi_record_stream_parser.f =====
src/prs_pkg.sv
src/prs_front.sv
src/prs_queue.sv
src/prs_back.sv
src/poi_record_stream_parser.sv
tb/poi_record_stream_parser_test.sv
